FILE: design/aldb_pkg.sv
// shared types, constants and register map of the ladder keypad decoder
package aldb_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 12;
    localparam int TIME_W   = 32;
    localparam int LONG_W   = 16;
    localparam int EVENT_W  = 3;

    // raw*3300/4095 == raw*220/273, and the divide by 273 is a reciprocal
    // multiply: ceil(2^29/273) = 1966561, exact for raw*220 below 2^20
    localparam int SCALE_SHIFT = 29;
    localparam int SCALE_W     = 29;
    localparam int PROD_W      = SAMPLE_W + SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE_MULT = 29'd432643420;

    typedef logic [EVENT_W-1:0] t_event;

    localparam t_event EV_NONE     = 3'd0;
    localparam t_event EV_SET      = 3'd1;
    localparam t_event EV_LONG_SET = 3'd2;
    localparam t_event EV_UP       = 3'd3;
    localparam t_event EV_DOWN     = 3'd4;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_RELEASE  = 3'd0;
    localparam t_reg_idx REG_SET_LOW  = 3'd1;
    localparam t_reg_idx REG_SET_HIGH = 3'd2;
    localparam t_reg_idx REG_UP_LOW   = 3'd3;
    localparam t_reg_idx REG_UP_HIGH  = 3'd4;
    localparam t_reg_idx REG_DN_LOW   = 3'd5;
    localparam t_reg_idx REG_DN_HIGH  = 3'd6;
    localparam t_reg_idx REG_LONG     = 3'd7;

    typedef struct packed {
        logic [MV_W-1:0]   release_level_mv;
        logic [MV_W-1:0]   set_band_low_mv;
        logic [MV_W-1:0]   set_band_high_mv;
        logic [MV_W-1:0]   up_band_low_mv;
        logic [MV_W-1:0]   up_band_high_mv;
        logic [MV_W-1:0]   down_band_low_mv;
        logic [MV_W-1:0]   down_band_high_mv;
        logic [LONG_W-1:0] long_press_ms;
    } t_cfg;

    localparam logic [MV_W-1:0]   RST_RELEASE  = 12'd3000;
    localparam logic [MV_W-1:0]   RST_SET_LOW  = 12'd100;
    localparam logic [MV_W-1:0]   RST_SET_HIGH = 12'd600;
    localparam logic [MV_W-1:0]   RST_UP_LOW   = 12'd900;
    localparam logic [MV_W-1:0]   RST_UP_HIGH  = 12'd1400;
    localparam logic [MV_W-1:0]   RST_DN_LOW   = 12'd1700;
    localparam logic [MV_W-1:0]   RST_DN_HIGH  = 12'd2200;
    localparam logic [LONG_W-1:0] RST_LONG     = 16'd5000;

    function automatic logic in_band(input logic [MV_W-1:0] mv,
                                     input logic [MV_W-1:0] lo,
                                     input logic [MV_W-1:0] hi);
        return (mv > lo) && (mv < hi);
    endfunction

endpackage

FILE: design/aldb_scale.sv
// converts a raw ladder sample to millivolts by reciprocal multiplication
module aldb_scale (
    input  logic [aldb_pkg::SAMPLE_W-1:0] i_raw,
    output logic [aldb_pkg::MV_W-1:0]     o_mv
);
    import aldb_pkg::*;

    logic [PROD_W-1:0] prod;

    assign prod = {{SCALE_W{1'b0}}, i_raw} * {{SAMPLE_W{1'b0}}, SCALE_MULT};
    assign o_mv = prod[SCALE_SHIFT +: MV_W];

endmodule

FILE: design/aldb_lane.sv
// one key channel: band classification, hold tracking and event choice
module aldb_lane #(
    parameter int REPEAT_MS = 500
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [aldb_pkg::MV_W-1:0]   i_mv,
    input  logic [aldb_pkg::TIME_W-1:0] i_now,
    input  aldb_pkg::t_cfg              i_cfg,
    output aldb_pkg::t_event            o_event
);
    import aldb_pkg::*;

    logic              r_held, n_held;
    logic [TIME_W-1:0] r_start, n_start;
    logic [MV_W-1:0]   r_prev;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] long_ms;
    logic              released, set_in, up_in, dn_in, prev_set;

    assign elapsed  = i_now - r_start;
    assign long_ms  = {{(TIME_W-LONG_W){1'b0}}, i_cfg.long_press_ms};
    assign released = i_mv > i_cfg.release_level_mv;
    assign set_in   = in_band(i_mv, i_cfg.set_band_low_mv, i_cfg.set_band_high_mv);
    assign up_in    = in_band(i_mv, i_cfg.up_band_low_mv, i_cfg.up_band_high_mv);
    assign dn_in    = in_band(i_mv, i_cfg.down_band_low_mv, i_cfg.down_band_high_mv);
    assign prev_set = in_band(r_prev, i_cfg.set_band_low_mv, i_cfg.set_band_high_mv);

    always_comb begin
        n_held  = r_held;
        n_start = r_start;
        o_event = EV_NONE;
        priority if (released) begin
            n_held = 1'b0;
            if (r_held && prev_set && (elapsed < long_ms)) begin
                o_event = EV_SET;
            end
        end else if (set_in) begin
            if (!r_held) begin
                n_held  = 1'b1;
                n_start = i_now;
            end else if (elapsed > long_ms) begin
                o_event = EV_LONG_SET;
            end
        end else if (up_in || dn_in) begin
            if (!r_held) begin
                n_held  = 1'b1;
                n_start = i_now;
            end else if (elapsed > TIME_W'(REPEAT_MS)) begin
                n_start = i_now;
                o_event = up_in ? EV_UP : EV_DOWN;
            end
        end else begin
            // pressed but outside every band: state stays as it is and no event is raised
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_start <= '0;
            r_prev  <= '0;
        end else if (i_en) begin
            r_held  <= n_held;
            r_start <= n_start;
            r_prev  <= i_mv;
        end
    end

endmodule

FILE: design/adc_ladder_button_decoder.sv
// two-channel resistor ladder keypad decoder with stream ports and apb registers
// pipeline: stage 1 scaling, then the lane update into the output register
// throughput: one poll per cycle while the output is not stalled, and the lane
//   state read-modify-write closes within one stage
// reset: synchronous active-low i_rst_n clears lane state, pipeline valids and loads
//   the register reset values; no clearing pass is needed
module adc_ladder_button_decoder #(
    parameter int REPEAT_MS = 500
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata, low bit up: right_sample[11:0], left_sample[23:12], now_ms[55:24]
    input  logic [55:0]                   i_s_tdata,
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata, low bit up: right_event[2:0], left_event[5:3], zero pad[7:6]
    output logic [7:0]                    o_m_tdata,
    // apb register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aldb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import aldb_pkg::*;

    // ---------------- configuration registers ----------------
    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2 +: REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_level_mv  <= RST_RELEASE;
            r_cfg.set_band_low_mv   <= RST_SET_LOW;
            r_cfg.set_band_high_mv  <= RST_SET_HIGH;
            r_cfg.up_band_low_mv    <= RST_UP_LOW;
            r_cfg.up_band_high_mv   <= RST_UP_HIGH;
            r_cfg.down_band_low_mv  <= RST_DN_LOW;
            r_cfg.down_band_high_mv <= RST_DN_HIGH;
            r_cfg.long_press_ms     <= RST_LONG;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RELEASE:  r_cfg.release_level_mv  <= pwdata[MV_W-1:0];
                REG_SET_LOW:  r_cfg.set_band_low_mv   <= pwdata[MV_W-1:0];
                REG_SET_HIGH: r_cfg.set_band_high_mv  <= pwdata[MV_W-1:0];
                REG_UP_LOW:   r_cfg.up_band_low_mv    <= pwdata[MV_W-1:0];
                REG_UP_HIGH:  r_cfg.up_band_high_mv   <= pwdata[MV_W-1:0];
                REG_DN_LOW:   r_cfg.down_band_low_mv  <= pwdata[MV_W-1:0];
                REG_DN_HIGH:  r_cfg.down_band_high_mv <= pwdata[MV_W-1:0];
                REG_LONG:     r_cfg.long_press_ms     <= pwdata[LONG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RELEASE:  prdata = {20'd0, r_cfg.release_level_mv};
            REG_SET_LOW:  prdata = {20'd0, r_cfg.set_band_low_mv};
            REG_SET_HIGH: prdata = {20'd0, r_cfg.set_band_high_mv};
            REG_UP_LOW:   prdata = {20'd0, r_cfg.up_band_low_mv};
            REG_UP_HIGH:  prdata = {20'd0, r_cfg.up_band_high_mv};
            REG_DN_LOW:   prdata = {20'd0, r_cfg.down_band_low_mv};
            REG_DN_HIGH:  prdata = {20'd0, r_cfg.down_band_high_mv};
            REG_LONG:     prdata = {16'd0, r_cfg.long_press_ms};
            default:      prdata = '0;
        endcase
    end

    // ---------------- stage 1: millivolt scaling ----------------
    logic [MV_W-1:0]   mv_r, mv_l;
    logic              r_s1_valid;
    logic [MV_W-1:0]   r_s1_mv_r, r_s1_mv_l;
    logic [TIME_W-1:0] r_s1_now;
    logic              advance;
    logic              lane_en;

    aldb_scale u_scale_r (
        .i_raw (i_s_tdata[11:0]),
        .o_mv  (mv_r)
    );

    aldb_scale u_scale_l (
        .i_raw (i_s_tdata[23:12]),
        .o_mv  (mv_l)
    );

    // the output register frees up when empty or when its transaction completes
    assign advance    = !o_m_tvalid || i_m_tready;
    // stage 1 takes a new poll when empty or when it moves on this cycle
    assign o_s_tready = !r_s1_valid || advance;
    assign lane_en    = r_s1_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_mv_r <= mv_r;
            r_s1_mv_l <= mv_l;
            r_s1_now  <= i_s_tdata[55:24];
        end
    end

    // ---------------- stage 2: per-channel lanes ----------------
    // lane state only moves when the poll leaves stage 1, so a stall never
    // replays an update
    t_event ev_r, ev_l;

    aldb_lane #(.REPEAT_MS(REPEAT_MS)) u_lane_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (lane_en),
        .i_mv    (r_s1_mv_r),
        .i_now   (r_s1_now),
        .i_cfg   (r_cfg),
        .o_event (ev_r)
    );

    aldb_lane #(.REPEAT_MS(REPEAT_MS)) u_lane_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (lane_en),
        .i_mv    (r_s1_mv_l),
        .i_now   (r_s1_now),
        .i_cfg   (r_cfg),
        .o_event (ev_l)
    );

    // ---------------- merge into the output register ----------------
    logic       r_out_valid;
    logic [7:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_en) begin
            r_out_data <= {2'b00, ev_l, ev_r};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // a full stage 1 behind a stalled output must hold off new input
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while pipeline is full and stalled");

    // an accepted poll always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_s1_valid)
        else $error("accepted transaction lost before stage 1");

    // a poll leaving stage 1 becomes a valid result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_en |=> o_m_tvalid)
        else $error("lane result not presented on output");

    // only defined event codes reach the output
    a_event_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= EV_DOWN) && (o_m_tdata[5:3] <= EV_DOWN))
        else $error("undefined event code on output");

endmodule
